FILE: rtl/core/bdc_pkg.sv
package bdc_pkg;

	// Opcodes of the request operation field
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	localparam int AXES   = 3;   // x, y, z
	localparam int IO_W   = 16;  // width of coordinates on the ports
	localparam int U_W    = 16;  // curve parameter, unsigned Q0.16
	localparam int IDX_W  = 4;   // point_index port width
	localparam int CNT_W  = 5;   // points_in_use port width
	localparam int MIN_PTS = 3;  // fewest points that give a curve point

endpackage

FILE: rtl/core/bezier_de_casteljau_evaluator.sv
// Load request: busy stays low. Evaluate with n points (saturated to MAX_POINTS): one
// interpolation pipe reads the control store, then the scratch memory, an entry per
// cycle with a gap state between levels; busy drops with done, so the next request is
// taken then. Fewer than three points: no result, busy stays low. done is high for a
// single cycle and the result holds until the next one; the receiver cannot stall it.
// Reset clears control state, not memories.
module bezier_de_casteljau_evaluator #(
	parameter int MAX_POINTS  = 16,
	parameter int COORD_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              operation,
	input  logic [bdc_pkg::IDX_W-1:0]         point_index,
	input  logic signed [bdc_pkg::IO_W-1:0]   point_x,
	input  logic signed [bdc_pkg::IO_W-1:0]   point_y,
	input  logic signed [bdc_pkg::IO_W-1:0]   point_z,
	input  logic [bdc_pkg::U_W-1:0]           param_u,
	input  logic [bdc_pkg::CNT_W-1:0]         points_in_use,
	output logic                              done,
	output logic signed [bdc_pkg::IO_W-1:0]   curve_x,
	output logic signed [bdc_pkg::IO_W-1:0]   curve_y,
	output logic signed [bdc_pkg::IO_W-1:0]   curve_z
);

	import bdc_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int AW = $clog2(MAX_POINTS);       // memory address width
	localparam int NW = $clog2(MAX_POINTS + 1);   // holds a point count
	localparam int DW = CW + 1;                   // q - p
	localparam int PW = DW + U_W + 1;             // (q - p) * u, exact

	// Sequencer states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_GAP   = 2'd2;
	localparam logic [1:0] ST_DRAIN = 2'd3;

	typedef logic [AXES-1:0][CW-1:0] point_t;

	logic [1:0]    state_q;
	logic [AW-1:0] rd_idx_q;      // entry read this cycle
	logic [AW-1:0] last_idx_q;    // highest entry read in this level
	logic          from_ctrl_q;   // first level reads the control store
	logic [U_W-1:0] u_q;

	// Stage 1: read data returns from memory
	logic          vld_s1, first_s1, final_s1, ctrl_s1;
	logic [AW-1:0] idx_s1;
	point_t        prev_q;        // entry read before the current one (p of the lerp)

	// Stage 2: products registered, sum and write back
	logic          vld_s2, final_s2;
	logic [AW-1:0] waddr_s2;
	point_t        p_s2;
	logic [AXES-1:0][PW-1:0] prod_s2;

	logic       done_q;
	point_t     res_q;

	// ------------------------------------------------------------------
	// Request decode
	// ------------------------------------------------------------------
	logic          accept;
	logic          load_req, eval_req;
	logic [NW-1:0] n_eff;
	logic          too_few;
	logic          ctrl_we;
	logic [AW-1:0] ctrl_waddr;
	point_t        ctrl_wdata;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign load_req = accept && (operation == OP_LOAD);
	assign eval_req = accept && (operation == OP_EVAL);

	always_comb begin
		// Saturate the point count to the store depth
		if (32'(points_in_use) > 32'(MAX_POINTS)) begin
			n_eff = NW'(MAX_POINTS);
		end else begin
			n_eff = NW'(points_in_use);
		end
	end
	assign too_few = (32'(n_eff) < 32'(MIN_PTS));

	// Drop loads that address a slot beyond the store
	assign ctrl_we    = load_req && (32'(point_index) < 32'(MAX_POINTS));
	assign ctrl_waddr = AW'(point_index);
	assign ctrl_wdata = {CW'(point_z), CW'(point_y), CW'(point_x)};

	// ------------------------------------------------------------------
	// Memories: control points and the working copy
	// ------------------------------------------------------------------
	point_t        ctrl_rdata, scr_rdata, scr_wdata;
	logic          scr_we;

	bdc_ram #(.WIDTH(AXES * CW), .DEPTH(MAX_POINTS)) u_ctrl_ram (
		.clk   (clk),
		.we    (ctrl_we),
		.waddr (ctrl_waddr),
		.wdata (ctrl_wdata),
		.raddr (rd_idx_q),
		.rdata (ctrl_rdata)
	);

	bdc_ram #(.WIDTH(AXES * CW), .DEPTH(MAX_POINTS)) u_scr_ram (
		.clk   (clk),
		.we    (scr_we),
		.waddr (waddr_s2),
		.wdata (scr_wdata),
		.raddr (rd_idx_q),
		.rdata (scr_rdata)
	);

	// ------------------------------------------------------------------
	// Sequencer: each level reads entries 0..last_idx in order and writes
	// lerp(entry j, entry j+1) back to entry j. The next level waits in the
	// gap state so its read of the top entry sees the last write of this level.
	// ------------------------------------------------------------------
	logic issue;
	assign issue = (state_q == ST_RUN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_idx_q    <= '0;
			last_idx_q  <= '0;
			from_ctrl_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (eval_req && !too_few) begin
						state_q     <= ST_RUN;
						rd_idx_q    <= '0;
						last_idx_q  <= AW'(n_eff - NW'(1));
						from_ctrl_q <= 1'b1;
					end
				end
				ST_RUN: begin
					if (rd_idx_q == last_idx_q) begin
						rd_idx_q <= '0;
						if (last_idx_q == AW'(1)) begin
							state_q <= ST_DRAIN;
						end else begin
							state_q     <= ST_GAP;
							last_idx_q  <= last_idx_q - AW'(1);
							from_ctrl_q <= 1'b0;
						end
					end else begin
						rd_idx_q <= rd_idx_q + AW'(1);
					end
				end
				ST_GAP: begin
					state_q <= ST_RUN;
				end
				ST_DRAIN: begin
					// hold busy until the final point leaves the pipe
					if (vld_s2 && final_s2) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (eval_req) begin
			u_q <= param_u;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1 control
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (rd_idx_q == '0);
		final_s1 <= (last_idx_q == AW'(1));
		ctrl_s1  <= from_ctrl_q;
		idx_s1   <= rd_idx_q;
	end

	// ------------------------------------------------------------------
	// Stage 1 -> 2: difference and multiply per axis
	// ------------------------------------------------------------------
	point_t q_s1;
	assign q_s1 = ctrl_s1 ? ctrl_rdata : scr_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1 && !first_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			prev_q <= q_s1;
		end
		final_s2 <= final_s1;
		waddr_s2 <= idx_s1 - AW'(1);
		p_s2     <= prev_q;
		for (int a = 0; a < AXES; a++) begin
			prod_s2[a] <= PW'(($signed(DW'($signed(q_s1[a])))
				- $signed(DW'($signed(prev_q[a]))))
				* $signed({1'b0, u_q}));
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: p + floor(prod / 2^16), written back or sent out
	// ------------------------------------------------------------------
	logic signed [PW-1:0] step [AXES];

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			step[a]      = $signed(prod_s2[a]) >>> U_W;
			scr_wdata[a] = p_s2[a] + step[a][CW-1:0];
		end
	end

	assign scr_we = vld_s2 && !final_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s2 && final_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2 && final_s2) begin
			res_q <= scr_wdata;
		end
	end

	assign done    = done_q;
	assign curve_x = IO_W'($signed(res_q[0]));
	assign curve_y = IO_W'($signed(res_q[1]));
	assign curve_z = IO_W'($signed(res_q[2]));

endmodule

FILE: rtl/core/bdc_ram.sv
module bdc_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: dv/bezier_de_casteljau_evaluator_tb.sv
module bezier_de_casteljau_evaluator_tb;

	import bdc_pkg::*;

	localparam int MAX_POINTS  = 16;
	localparam int NUM_ITEMS   = 1350;
	// Settle past the longest evaluate.
	localparam int SETTLE_CYCLES = 200;
	localparam int MAX_PRINTS    = 40;

	// One request as queued for the driver, with its pacing attached.
	typedef struct {
		logic                   operation;
		logic [IDX_W-1:0]       point_index;
		logic signed [IO_W-1:0] point_x;
		logic signed [IO_W-1:0] point_y;
		logic signed [IO_W-1:0] point_z;
		logic [U_W-1:0]         param_u;
		logic [CNT_W-1:0]       points_in_use;
		int                     idle_pct;  // chance per cycle of holding start low
		bit                     drain;     // hold until every curve point is back
	} bezier_req_t;

	typedef struct packed {
		logic signed [IO_W-1:0] x;
		logic signed [IO_W-1:0] y;
		logic signed [IO_W-1:0] z;
	} curve_pt_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                   start         = 1'b0;
	logic                   operation     = OP_LOAD;
	logic [IDX_W-1:0]       point_index   = '0;
	logic signed [IO_W-1:0] point_x       = '0;
	logic signed [IO_W-1:0] point_y       = '0;
	logic signed [IO_W-1:0] point_z       = '0;
	logic [U_W-1:0]         param_u       = '0;
	logic [CNT_W-1:0]       points_in_use = '0;

	logic                   busy;
	logic                   done;
	logic signed [IO_W-1:0] curve_x;
	logic signed [IO_W-1:0] curve_y;
	logic signed [IO_W-1:0] curve_z;

	bezier_req_t pending_requests[$];
	curve_pt_t   pending_curve_points[$];

	// Control points as the block should hold them after every accepted load.
	logic signed [IO_W-1:0] ctrl_pts [MAX_POINTS][AXES];

	int mismatch_count = 0;
	bit req_taken      = 1'b0;

	// Generator pacing state, stamped onto each queued request.
	int cur_idle_pct   = 20;
	bit drain_next     = 1'b0;
	int queued_items   = 0;

	bezier_de_casteljau_evaluator #(
		.MAX_POINTS  (MAX_POINTS),
		.COORD_WIDTH (IO_W)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.operation     (operation),
		.point_index   (point_index),
		.point_x       (point_x),
		.point_y       (point_y),
		.point_z       (point_z),
		.param_u       (param_u),
		.points_in_use (points_in_use),
		.done          (done),
		.curve_x       (curve_x),
		.curve_y       (curve_y),
		.curve_z       (curve_z)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Run de Casteljau on a fresh copy of the control points. Each step is
	// p + floor(u * (q - p) / 2^16); an arithmetic shift of the signed product
	// gives the floor directly. Results stay in the hull, so 16 bits hold them.
	function automatic curve_pt_t eval_curve(logic [U_W-1:0] u, int n);
		longint    work [MAX_POINTS][AXES];
		longint    u_ext;
		curve_pt_t pt;
		u_ext = longint'(u);
		for (int j = 0; j < MAX_POINTS; j++)
			for (int a = 0; a < AXES; a++)
				work[j][a] = longint'(ctrl_pts[j][a]);
		for (int lvl = 1; lvl < n; lvl++)
			for (int j = 0; j + lvl < n; j++)
				for (int a = 0; a < AXES; a++)
					work[j][a] = work[j][a] + (((work[j + 1][a] - work[j][a]) * u_ext) >>> 16);
		pt.x = IO_W'(work[0][0]);
		pt.y = IO_W'(work[0][1]);
		pt.z = IO_W'(work[0][2]);
		return pt;
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS)
			$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic logic signed [IO_W-1:0] extreme_coord(int k);
		case (k % 4)
			0:       return 16'sh7FFF;
			1:       return 16'sh8000;
			2:       return 16'sh0000;
			default: return 16'shFFFF;
		endcase
	endfunction

	function automatic logic signed [IO_W-1:0] rand_coord();
		logic signed [IO_W-1:0] c;
		c = IO_W'($urandom);
		if ($urandom_range(7) == 0)
			c = extreme_coord($urandom_range(3));
		return c;
	endfunction

	function automatic logic [U_W-1:0] rand_u();
		logic [U_W-1:0] u;
		u = U_W'($urandom);
		case ($urandom_range(11))
			0:       u = '0;
			1:       u = '1;
			2:       u = 16'h0001;
			3:       u = 16'h8000;
			default: ;
		endcase
		return u;
	endfunction

	// Pick a curve size: mostly short curves to keep evaluates fast, some long
	// ones up to MAX_POINTS, and now and then a count past MAX_POINTS to hit saturation.
	function automatic int rand_curve_size();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return $urandom_range(5, MIN_PTS);
		else if (r < 85)
			return $urandom_range(10, 6);
		else if (r < 95)
			return $urandom_range(MAX_POINTS, 11);
		return $urandom_range(31, MAX_POINTS + 1);
	endfunction

	// Queue a load; the evaluate-only fields carry noise the block must ignore.
	task automatic push_load(input int idx, input logic signed [IO_W-1:0] x,
			input logic signed [IO_W-1:0] y, input logic signed [IO_W-1:0] z);
		bezier_req_t r;
		r.operation     = OP_LOAD;
		r.point_index   = IDX_W'(idx);
		r.point_x       = x;
		r.point_y       = y;
		r.point_z       = z;
		r.param_u       = U_W'($urandom);
		r.points_in_use = CNT_W'($urandom);
		r.idle_pct      = cur_idle_pct;
		r.drain         = drain_next;
		drain_next      = 1'b0;
		pending_requests = {pending_requests, r};
		queued_items++;
	endtask

	// Queue an evaluate; the load-only fields carry noise.
	task automatic push_eval(input logic [U_W-1:0] u, input int n);
		bezier_req_t r;
		r.operation     = OP_EVAL;
		r.point_index   = IDX_W'($urandom);
		r.point_x       = IO_W'($urandom);
		r.point_y       = IO_W'($urandom);
		r.point_z       = IO_W'($urandom);
		r.param_u       = u;
		r.points_in_use = CNT_W'(n);
		r.idle_pct      = cur_idle_pct;
		r.drain         = drain_next;
		drain_next      = 1'b0;
		pending_requests = {pending_requests, r};
		// A too-short curve is dropped by the block; leave it out of the count.
		if (n >= MIN_PTS)
			queued_items++;
	endtask

	// ------------------------------------------------------------------
	// Request list
	// ------------------------------------------------------------------

	initial begin
		int n;
		int n_eff;
		int phase_idle;

		// Directed: fill every slot with extremes, so no evaluate below ever
		// reaches a slot that was never written.
		for (int i = 0; i < MAX_POINTS; i++)
			push_load(i, extreme_coord(i), extreme_coord(i + 1), extreme_coord(i + 2));
		push_eval(16'h0000, MIN_PTS);        // u = 0 returns the first point
		push_eval(16'hFFFF, MIN_PTS);        // u at its top, near the last point
		drain_next = 1'b1;
		push_eval(16'h8000, MAX_POINTS);     // full curve, midpoint
		push_eval(16'h0001, MAX_POINTS);
		push_eval(16'hFFFF, 31);             // count saturates to MAX_POINTS
		push_eval(16'h1234, MAX_POINTS + 1);
		push_eval(16'h0000, 0);              // too few points: no result
		push_eval(16'hFFFF, 1);
		push_eval(16'h8000, MIN_PTS - 1);

		// Random: mostly well-formed curves (reload some points, then sweep a
		// few u values), the rest single loads and stray evaluates.
		while (queued_items < NUM_ITEMS) begin
			phase_idle = (queued_items < NUM_ITEMS / 3) ? 20 :
				(queued_items < 2 * NUM_ITEMS / 3) ? 64 : 0;
			if (phase_idle != cur_idle_pct) begin
				cur_idle_pct = phase_idle;
				drain_next   = 1'b1;
			end
			if ($urandom_range(99) == 0)
				drain_next = 1'b1;
			if ($urandom_range(9) < 7) begin
				n     = rand_curve_size();
				n_eff = (n > MAX_POINTS) ? MAX_POINTS : n;
				for (int i = 0; i < n_eff; i++)
					if ($urandom_range(1) == 0)
						push_load(i, rand_coord(), rand_coord(), rand_coord());
				repeat ($urandom_range(4, 1))
					push_eval(rand_u(), n);
			end else begin
				case ($urandom_range(2))
					0:       push_load($urandom_range(MAX_POINTS - 1), rand_coord(),
							rand_coord(), rand_coord());
					1:       push_eval(rand_u(), $urandom_range(MIN_PTS - 1));
					default: push_eval(rand_u(), $urandom_range(31, MIN_PTS));
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Driver: change inputs on the falling edge
	// ------------------------------------------------------------------

	always @(negedge clk) begin
		if (arst_n) begin
			// Hold the current request until the monitor has seen it taken.
			if (!start || req_taken) begin
				req_taken = 1'b0;
				if (pending_requests.size() == 0 ||
						(pending_requests[0].drain && pending_curve_points.size() != 0) ||
						$urandom_range(99) < pending_requests[0].idle_pct) begin
					// Idle: drop start and scramble the payload.
					start         <= 1'b0;
					operation     <= 1'($urandom);
					point_index   <= IDX_W'($urandom);
					point_x       <= IO_W'($urandom);
					point_y       <= IO_W'($urandom);
					point_z       <= IO_W'($urandom);
					param_u       <= U_W'($urandom);
					points_in_use <= CNT_W'($urandom);
				end else begin
					start         <= 1'b1;
					operation     <= pending_requests[0].operation;
					point_index   <= pending_requests[0].point_index;
					point_x       <= pending_requests[0].point_x;
					point_y       <= pending_requests[0].point_y;
					point_z       <= pending_requests[0].point_z;
					param_u       <= pending_requests[0].param_u;
					points_in_use <= pending_requests[0].points_in_use;
					void'(pending_requests.pop_front());
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: sample on the rising edge, check results, predict requests
	// ------------------------------------------------------------------

	always @(posedge clk) begin : monitor
		curve_pt_t want;
		int        n;
		if (arst_n) begin
			// Check the strobed curve point against the oldest prediction.
			if (done) begin
				if (pending_curve_points.size() == 0) begin
					flag_mismatch($sformatf("curve point (%0d,%0d,%0d) with none expected",
						curve_x, curve_y, curve_z));
				end else begin
					want = pending_curve_points.pop_front();
					if (curve_x !== want.x)
						flag_mismatch($sformatf("curve_x %0d, expected %0d", curve_x, want.x));
					if (curve_y !== want.y)
						flag_mismatch($sformatf("curve_y %0d, expected %0d", curve_y, want.y));
					if (curve_z !== want.z)
						flag_mismatch($sformatf("curve_z %0d, expected %0d", curve_z, want.z));
				end
			end
			// Advance the model on every accepted request, from the port values.
			if (start && !busy) begin
				req_taken = 1'b1;
				if (operation == OP_LOAD) begin
					if (point_index < MAX_POINTS) begin
						ctrl_pts[point_index][0] = point_x;
						ctrl_pts[point_index][1] = point_y;
						ctrl_pts[point_index][2] = point_z;
					end
				end else begin
					n = (points_in_use > MAX_POINTS) ? MAX_POINTS : int'(points_in_use);
					if (n >= MIN_PTS)
						pending_curve_points = {pending_curve_points, eval_curve(param_u, n)};
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Reset, end of run
	// ------------------------------------------------------------------

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		// Release on the falling edge so the driver starts on the next one.
		@(negedge clk);
		arst_n <= 1'b1;
		// Wait for the last request to be taken and every curve point to return.
		do
			@(posedge clk);
		while (pending_requests.size() != 0 || start || pending_curve_points.size() != 0);
		// Give a stray strobe time to show up.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_curve_points.size() == 0)
			$display("bezier_de_casteljau_evaluator test passed");
		else
			$display("bezier_de_casteljau_evaluator test failed");
		$finish;
	end

	// Hard stop, far beyond the slowest legal run (every evaluate at full size
	// with the longest idle stretches).
	initial begin
		#3000000;
		$display("bezier_de_casteljau_evaluator test failed");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/bdc_pkg.sv
rtl/core/bdc_ram.sv
rtl/core/bezier_de_casteljau_evaluator.sv
dv/bezier_de_casteljau_evaluator_tb.sv
